FILE: hdl/kcst_pkg.sv
// package: word types, operation and status codes, controller types for the slot table
`default_nettype none
package kcst_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int KEY_W          = 256;
	localparam int SLOT_W         = 4;
	localparam int COUNT_W        = 5;
	localparam int COUNT_MAX      = 31;

	localparam logic [1:0] FUNC_PUT    = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_WIPE   = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [7:0]  id_length;
		logic [3:0]  match_index;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] match_count;
	} rsp_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic wipe;
		logic write;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       scan_done;
		logic       out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/kcst_ctrl.sv
// controller: sequences accept, slot scan or wipe, table write and result hand-off
`default_nettype none
module kcst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire kcst_pkg::dp_status_t st,
	output kcst_pkg::ctrl_cmd_t      cmd
);

	kcst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			kcst_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = kcst_pkg::S_SCAN;
				end
			end
			kcst_pkg::S_SCAN: begin
				if (st.func == kcst_pkg::FUNC_PUT || st.func == kcst_pkg::FUNC_LOOKUP) begin
					cmd.scan = 1'b1;
					if (st.scan_done) begin
						state_d = (st.func == kcst_pkg::FUNC_PUT) ? kcst_pkg::S_WRITE
							: kcst_pkg::S_DONE;
					end
				end else begin
					cmd.wipe = (st.func == kcst_pkg::FUNC_WIPE);
					state_d  = kcst_pkg::S_DONE;
				end
			end
			kcst_pkg::S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = kcst_pkg::S_DONE;
			end
			kcst_pkg::S_DONE: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = kcst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kcst_pkg::S_IDLE;
			end
		endcase
	end

	a_write_after_put_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kcst_pkg::S_WRITE |-> $past(state_q) == kcst_pkg::S_SCAN
			&& $past(st.func) == kcst_pkg::FUNC_PUT)
		else $error("table write not preceded by a put scan");

	a_put_scan_goes_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kcst_pkg::S_SCAN && st.scan_done && st.func == kcst_pkg::FUNC_PUT)
			|=> state_q == kcst_pkg::S_WRITE)
		else $error("finished put scan skipped the write");

	a_idle_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == kcst_pkg::S_IDLE && !req_stall)
		else $error("not ready after result load");

endmodule
`default_nettype wire

FILE: hdl/kcst_dpath.sv
// datapath: key memory, occupancy flags, match/free search and result register
`default_nettype none
module kcst_dpath #(
	parameter int SLOT_COUNT = kcst_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kcst_pkg::req_word_t req,
	input  wire kcst_pkg::ctrl_cmd_t cmd,
	output kcst_pkg::dp_status_t     st,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output kcst_pkg::rsp_word_t      rsp
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
	localparam int SAT_W = (CNT_W > kcst_pkg::COUNT_W) ? CNT_W : kcst_pkg::COUNT_W;

	kcst_pkg::req_word_t req_q;
	logic [kcst_pkg::KEY_W-1:0] key_mem [SLOT_COUNT];
	logic [kcst_pkg::KEY_W-1:0] key_s1;
	logic [kcst_pkg::KEY_W-1:0] req_key;
	logic [SLOT_COUNT-1:0]      occupied_q;
	logic [CNT_W-1:0]           rd_cnt_q;
	logic [IDX_W-1:0]           rd_idx;
	logic                       rd_go;
	logic                       cmp_v_s1;
	logic [IDX_W-1:0]           cmp_idx_s1;
	logic                       hit, free_hit, nth_hit;
	logic                       have_free_q, have_match_q, found_q;
	logic [IDX_W-1:0]           free_slot_q, match_slot_q, found_slot_q;
	logic [CNT_W-1:0]           count_q;
	logic                       have_target;
	logic [IDX_W-1:0]           target;
	kcst_pkg::rsp_word_t        result;

	assign req_key = {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
	assign rd_idx  = rd_cnt_q[IDX_W-1:0];
	assign rd_go   = cmd.scan && (rd_cnt_q != CNT_W'(SLOT_COUNT));

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// key memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write && have_target) begin
			key_mem[target] <= req_key;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			key_s1 <= key_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q   <= '0;
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_v_s1 <= rd_go;
			if (rd_go) begin
				cmp_idx_s1 <= rd_idx;
			end
			if (cmd.load) begin
				rd_cnt_q <= '0;
			end else if (rd_go) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	// compare stage
	assign hit      = cmp_v_s1 && occupied_q[cmp_idx_s1] && (key_s1 == req_key);
	assign free_hit = cmp_v_s1 && !occupied_q[cmp_idx_s1];
	assign nth_hit  = hit && !found_q && (CMP_W'(count_q) == CMP_W'(req_q.match_index));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_free_q  <= 1'b0;
			have_match_q <= 1'b0;
			found_q      <= 1'b0;
			count_q      <= '0;
		end else if (cmd.load) begin
			have_free_q  <= 1'b0;
			have_match_q <= 1'b0;
			found_q      <= 1'b0;
			count_q      <= '0;
		end else begin
			if (free_hit && !have_free_q) begin
				have_free_q <= 1'b1;
			end
			if (hit && !have_match_q) begin
				have_match_q <= 1'b1;
			end
			if (nth_hit) begin
				found_q <= 1'b1;
			end
			if (hit) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_hit && !have_free_q) begin
			free_slot_q <= cmp_idx_s1;
		end
		if (hit && !have_match_q) begin
			match_slot_q <= cmp_idx_s1;
		end
		if (nth_hit) begin
			found_slot_q <= cmp_idx_s1;
		end
	end

	// an existing entry for the key wins over the lowest free slot
	assign have_target = have_match_q || have_free_q;
	assign target      = have_match_q ? match_slot_q : free_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= '0;
		end else if (cmd.wipe) begin
			occupied_q <= '0;
		end else if (cmd.write && have_target) begin
			occupied_q[target] <= (req_q.id_length != 8'd0);
		end
	end

	always_comb begin
		result = '0;
		unique case (req_q.func)
			kcst_pkg::FUNC_PUT: begin
				result.status = have_target ? kcst_pkg::STAT_OK : kcst_pkg::STAT_FULL;
				result.slot   = have_target ? kcst_pkg::SLOT_W'(target) : '0;
			end
			kcst_pkg::FUNC_LOOKUP: begin
				result.status = found_q ? kcst_pkg::STAT_OK : kcst_pkg::STAT_MISS;
				result.slot   = found_q ? kcst_pkg::SLOT_W'(found_slot_q) : '0;
				if (SAT_W'(count_q) > SAT_W'(kcst_pkg::COUNT_MAX)) begin
					result.match_count = kcst_pkg::COUNT_W'(kcst_pkg::COUNT_MAX);
				end else begin
					result.match_count = kcst_pkg::COUNT_W'(count_q);
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp <= result;
		end
	end

	assign st.func      = req_q.func;
	assign st.scan_done = (rd_cnt_q == CNT_W'(SLOT_COUNT)) && !cmp_v_s1;
	assign st.out_busy  = rsp_valid && rsp_stall;

	a_cmp_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> $past(rd_go))
		else $error("compare stage valid without a read");

	a_full_put_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write && !have_target) |=> $stable(occupied_q))
		else $error("occupancy changed on a full put");

	a_found_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> count_q != '0)
		else $error("lookup found with zero matches");

	a_no_overwrite_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall && !cmd.out_load) |=> $stable(rsp))
		else $error("held result word overwritten");

endmodule
`default_nettype wire

FILE: hdl/keyed_credential_slot_table.sv
// top level: keyed credential slot table, controller plus datapath
`default_nettype none
// keyed credential slot table
// req channel: req_valid/req_stall with one request word (func, 256-bit site hash
//   as four 64-bit words, id_length, match_index); a word is taken when valid is
//   high and stall is low
// rsp channel: rsp_valid/rsp_stall with one result word (status, slot, match_count)
//   for every request word, in order
// timing: a put or lookup reads one slot of the key memory per cycle through its
//   single registered read port; a wipe and the unused code do no scan
// hand-off: the next word can be taken in the cycle after the result is loaded
// req_stall is high from accept until the result is loaded into the output
//   register; the next word can be taken while that result still waits
// a stalled result holds in the output register; a finished operation waits
//   in the done state until the register frees
// reset clears the occupancy flags (every slot free) and all control state; the
//   key memory is not cleared, keys are only compared for occupied slots
// record bodies live elsewhere, addressed by the returned slot
module keyed_credential_slot_table #(
	parameter int SLOT_COUNT = kcst_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire kcst_pkg::req_word_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output kcst_pkg::rsp_word_t      rsp
);

	// command and status between controller and datapath
	kcst_pkg::ctrl_cmd_t  cmd;
	kcst_pkg::dp_status_t st;

	// sequencer: idle, scan, write, done
	kcst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// key memory, occupancy, search and output register
	kcst_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
